[hdl/mqts_pkg.sv]
package mqts_pkg;

  // Default number of task slots.
  localparam int unsigned SLOTS_DEF = 16;

  // Level codes. Level one is the highest priority.
  localparam logic [2:0] LVL_SJF     = 3'd1;
  localparam logic [2:0] LVL_RR_LO   = 3'd2;
  localparam logic [2:0] LVL_RR_HI   = 3'd3;
  localparam logic [2:0] LVL_BATCH   = 3'd4;
  localparam logic [2:0] LVL_STUDENT = 3'd5;

  // Token lane that carries the oldest task returning from I/O.
  localparam int unsigned RET_LANE = 0;

  localparam logic [9:0] WAIT_MAX = 10'd1023;

  // Configuration register indexes.
  localparam logic [2:0] CFG_QUANTUM       = 3'd0;
  localparam logic [2:0] CFG_BATCH_LIMIT   = 3'd1;
  localparam logic [2:0] CFG_STUDENT_LIMIT = 3'd2;
  localparam logic [2:0] CFG_BATCH_BOOST   = 3'd3;
  localparam logic [2:0] CFG_STUDENT_BOOST = 3'd4;

  // Configuration reset values.
  localparam logic [1:0] QUANTUM_RST       = 2'd3;
  localparam logic [9:0] BATCH_LIMIT_RST   = 10'd100;
  localparam logic [9:0] STUDENT_LIMIT_RST = 10'd250;
  localparam logic [4:0] BATCH_BOOST_RST   = 5'd30;
  localparam logic [4:0] STUDENT_BOOST_RST = 5'd12;

  localparam logic OP_ADMIT = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [3:0] slot;
    logic [2:0] level;
    logic [1:0] burst_offset;
    logic [1:0] io_offset;
  } in_t;

  typedef struct packed {
    logic       run_valid;
    logic [3:0] run_slot;
    logic [2:0] run_level;
    logic       burst_done;
    logic       boosted;
  } out_t;

  // One candidate carried along the cell chain.
  typedef struct packed {
    logic        valid;
    logic [15:0] order;
    logic [3:0]  cpu;
    logic [9:0]  waited;
    logic [1:0]  slice;
  } cand_t;

  // Lane zero: I/O return candidate. Lanes one to five: level heads.
  typedef struct packed {
    cand_t [5:0] c;
  } tok_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_ADMIT,
    CMD_WAIT,
    CMD_RETURN,
    CMD_STAMP,
    CMD_FINISH
  } cmd_op_e;

  // Command broadcast to every cell.
  typedef struct packed {
    cmd_op_e     op;
    logic [2:0]  level;
    logic [1:0]  boff;
    logic [1:0]  ioff;
    logic [1:0]  qeff;
    logic [15:0] stamp;
    logic        sel;
    logic        clr;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADMIT,
    S_PASS_A,
    S_WAIT,
    S_PASS_RET,
    S_RET_APPLY,
    S_ROTATE,
    S_PASS_C,
    S_FINISH
  } state_e;

  function automatic logic [3:0] burst_base(input logic [2:0] lvl);
    logic [3:0] b;
    case (lvl)
      3'd1: b = 4'd1;
      3'd2: b = 4'd3;
      3'd3: b = 4'd4;
      3'd4: b = 4'd6;
      3'd5: b = 4'd8;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] io_base(input logic [2:0] lvl);
    logic [3:0] b;
    case (lvl)
      3'd1: b = 4'd8;
      3'd2: b = 4'd6;
      3'd3: b = 4'd4;
      3'd4: b = 4'd3;
      3'd5: b = 4'd1;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

endpackage

[hdl/mqts_cell.sv]
module mqts_cell #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned IDX   = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mqts_pkg::cmd_t                      cmd_i,
  input  logic [$clog2(SLOTS)-1:0]            tgt_i,
  input  mqts_pkg::tok_t                      tok_i,
  input  logic [5:0][$clog2(SLOTS)-1:0]       tok_slot_i,
  output mqts_pkg::tok_t                      tok_o,
  output logic [5:0][$clog2(SLOTS)-1:0]       tok_slot_o
);
  import mqts_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);

  logic        valid_q, valid_d;
  logic [2:0]  level_q, level_d;
  logic [3:0]  cpu_q, cpu_d;
  logic [3:0]  io_q, io_d;
  logic        in_io_q, in_io_d;
  logic [9:0]  wait_q, wait_d;
  logic [1:0]  slice_q, slice_d;
  logic [15:0] order_q, order_d;

  tok_t                 tok_q, tok_d;
  logic [5:0][SW-1:0]   slot_q, slot_d;

  logic        me;
  logic        ready;
  logic [15:0] my_age;
  logic [15:0] cand_age;
  logic        better;
  logic [3:0]  cpu_run;
  cand_t       mine;

  assign me     = (tgt_i == SW'(IDX));
  assign ready  = valid_q && !in_io_q;
  assign my_age = cmd_i.stamp - order_q;
  assign mine   = '{valid: 1'b1, order: order_q, cpu: cpu_q, waited: wait_q, slice: slice_q};

  // Compare this entry with the incoming candidates and pass the winners on.
  always_comb begin
    tok_d  = tok_i;
    slot_d = tok_slot_i;
    for (int l = 0; l < 6; l++) begin
      cand_age = cmd_i.stamp - tok_i.c[l].order;
      if (l == RET_LANE) begin
        better = valid_q && in_io_q && (io_q == 4'd0) &&
                 (!tok_i.c[l].valid || (my_age > cand_age));
      end else if (l == 1) begin
        better = ready && (level_q == 3'(l)) &&
                 (!tok_i.c[l].valid || (cpu_q < tok_i.c[l].cpu) ||
                  ((cpu_q == tok_i.c[l].cpu) && (my_age > cand_age)));
      end else begin
        better = ready && (level_q == 3'(l)) &&
                 (!tok_i.c[l].valid || (my_age > cand_age));
      end
      if (better) begin
        tok_d.c[l] = mine;
        slot_d[l]  = SW'(IDX);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    slot_q <= slot_d;
  end

  assign tok_o      = tok_q;
  assign tok_slot_o = slot_q;

  assign cpu_run = (cpu_q != 4'd0) ? cpu_q - 4'd1 : 4'd0;

  // Entry update for the broadcast command.
  always_comb begin
    valid_d = valid_q;
    level_d = level_q;
    cpu_d   = cpu_q;
    io_d    = io_q;
    in_io_d = in_io_q;
    wait_d  = wait_q;
    slice_d = slice_q;
    order_d = order_q;
    case (cmd_i.op)
      CMD_ADMIT: begin
        if (me) begin
          valid_d = 1'b1;
          level_d = cmd_i.level;
          cpu_d   = burst_base(cmd_i.level) + {2'b00, cmd_i.boff};
          io_d    = 4'd0;
          in_io_d = 1'b0;
          wait_d  = 10'd0;
          slice_d = cmd_i.qeff;
          order_d = cmd_i.stamp;
        end
      end
      CMD_WAIT: begin
        if (ready && !(cmd_i.sel && me) && (wait_q != WAIT_MAX)) begin
          wait_d = wait_q + 10'd1;
        end
      end
      CMD_RETURN: begin
        if (me) begin
          in_io_d = 1'b0;
          cpu_d   = burst_base(level_q) + {2'b00, cmd_i.boff};
          order_d = cmd_i.stamp;
        end
      end
      CMD_STAMP: begin
        if (me) begin
          order_d = cmd_i.stamp;
        end
      end
      CMD_FINISH: begin
        if (valid_q && in_io_q && (io_q != 4'd0)) begin
          io_d = io_q - 4'd1;
        end
        if (me && cmd_i.clr) begin
          wait_d = 10'd0;
        end
        if (me && cmd_i.sel) begin
          cpu_d = cpu_run;
          if (cpu_run == 4'd0) begin
            in_io_d = 1'b1;
            io_d    = io_base(level_q) + {2'b00, cmd_i.ioff};
            slice_d = cmd_i.qeff;
            order_d = cmd_i.stamp;
          end else if ((level_q == LVL_RR_LO) || (level_q == LVL_RR_HI)) begin
            slice_d = (slice_q <= 2'd1) ? cmd_i.qeff : slice_q - 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      level_q <= 3'd0;
      cpu_q   <= 4'd0;
      io_q    <= 4'd0;
      in_io_q <= 1'b0;
      wait_q  <= 10'd0;
      slice_q <= 2'd0;
      order_q <= 16'd0;
    end else begin
      valid_q <= valid_d;
      level_q <= level_d;
      cpu_q   <= cpu_d;
      io_q    <= io_d;
      in_io_q <= in_io_d;
      wait_q  <= wait_d;
      slice_q <= slice_d;
      order_q <= order_d;
    end
  end

endmodule

[hdl/multilevel_queue_tick_scheduler.sv]
// Five-level tick scheduler over a row of task slot cells.
// Input channel (in_valid_i, in_stall_o, in_data_i) takes admit and tick
// items; output channel (out_valid_o, out_stall_i, out_data_o) returns one
// result per item. An admit result is all zero; a tick result names the
// task that ran, whether it finished its burst and whether aging chose it.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i.
// One item is taken at a time. A tick scans the cell chain several times:
// once before the wait update, once per task returning from I/O plus once
// more, and once for the final pick. Each scan runs the whole length of the
// chain, so the number of slots and the number of returns set how long a
// tick takes.
// The result sits in an output register, so the next item is accepted while
// it waits. When the receiver stalls and a result is still held, the block
// holds its last step until the register frees.
// Reset empties all slots, clears the aging and rotation state and loads
// the default configuration.
module multilevel_queue_tick_scheduler #(
  parameter int unsigned SLOTS = mqts_pkg::SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mqts_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mqts_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [9:0]     cfg_data_i
);
  import mqts_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  state_e state_q, state_d;

  logic [CW-1:0] cnt_q;
  in_t           in_q;
  logic [4:0]    boost_q;
  logic [15:0]   oc_q;
  logic          last_v_q;
  logic [SW-1:0] last_q;
  logic          rot_q;
  logic          out_valid_q;
  out_t          out_q;

  logic [1:0] quantum_q;
  logic [9:0] batch_lim_q, student_lim_q;
  logic [4:0] batch_boost_q, student_boost_q;

  logic          pick_v_q;
  logic [SW-1:0] pick_slot_q;
  logic [2:0]    pick_lvl_q;
  logic          clr_q, boosted_q, done_q, rot_set_q;
  logic [SW-1:0] ret_slot_q;

  cmd_t          cmd;
  logic [SW-1:0] tgt;

  tok_t                chain [SLOTS+1];
  logic [5:0][SW-1:0]  chain_slot [SLOTS+1];

  logic       accept;
  logic       out_free;
  logic       pass_end;
  logic       admit_ok;
  logic [1:0] qeff;
  logic       st4, st5;
  tok_t       tail;

  // Pick decision taken from the tail of the final scan.
  logic          dec_v;
  logic [SW-1:0] dec_slot;
  logic [2:0]    dec_lvl;
  cand_t         dec_cand;
  logic          dec_clr, dec_boosted;
  logic [4:0]    dec_boost;
  logic [4:0]    boost_inc;
  logic [4:0]    boost_lim;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign pass_end = (cnt_q == CW'(SLOTS));
  assign qeff     = (quantum_q == 2'd0) ? 2'd1 : quantum_q;
  assign admit_ok = ({28'd0, in_q.slot} < 32'(SLOTS)) &&
                    (in_q.level >= LVL_SJF) && (in_q.level <= LVL_STUDENT);
  assign tail     = chain[SLOTS];
  assign st4 = tail.c[LVL_BATCH].valid && (tail.c[LVL_BATCH].waited > batch_lim_q);
  assign st5 = tail.c[LVL_STUDENT].valid &&
               (tail.c[LVL_STUDENT].waited > student_lim_q);

  // Cell chain: lane winners move one cell per cycle.
  assign chain[0]      = '0;
  assign chain_slot[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    mqts_cell #(
      .SLOTS(SLOTS),
      .IDX  (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .tgt_i     (tgt),
      .tok_i     (chain[i]),
      .tok_slot_i(chain_slot[i]),
      .tok_o     (chain[i+1]),
      .tok_slot_o(chain_slot[i+1])
    );
  end

  // Aging and normal pick at the end of the final scan.
  assign boost_inc = boost_q + 5'd1;
  assign boost_lim = st4 ? batch_boost_q : student_boost_q;

  always_comb begin
    dec_v       = 1'b0;
    dec_slot    = '0;
    dec_lvl     = 3'd0;
    dec_cand    = '0;
    dec_clr     = 1'b0;
    dec_boosted = 1'b0;
    dec_boost   = boost_q;
    if (boost_q != 5'd0) begin
      if (st4 || st5) begin
        dec_v       = 1'b1;
        dec_boosted = 1'b1;
        dec_lvl     = st4 ? LVL_BATCH : LVL_STUDENT;
        dec_slot    = chain_slot[SLOTS][dec_lvl];
        dec_cand    = tail.c[dec_lvl];
        dec_clr     = (boost_inc >= boost_lim);
        dec_boost   = dec_clr ? 5'd0 : boost_inc;
      end else begin
        dec_boost = 5'd0;
      end
    end
    if (!dec_v) begin
      for (int l = 5; l >= 1; l--) begin
        if (tail.c[l].valid) begin
          dec_v    = 1'b1;
          dec_lvl  = 3'(l);
          dec_slot = chain_slot[SLOTS][l];
          dec_cand = tail.c[l];
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.op == OP_TICK) ? S_PASS_A : S_ADMIT;
        end
      end
      S_ADMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_PASS_A: begin
        if (pass_end) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: state_d = S_PASS_RET;
      S_PASS_RET: begin
        if (pass_end) begin
          state_d = tail.c[RET_LANE].valid ? S_RET_APPLY : S_ROTATE;
        end
      end
      S_RET_APPLY: state_d = S_PASS_RET;
      S_ROTATE:    state_d = S_PASS_C;
      S_PASS_C: begin
        if (pass_end) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Command to the cells.
  always_comb begin
    cmd       = '0;
    cmd.op    = CMD_NONE;
    cmd.level = in_q.level;
    cmd.boff  = in_q.burst_offset;
    cmd.ioff  = in_q.io_offset;
    cmd.qeff  = qeff;
    cmd.stamp = oc_q;
    tgt       = '0;
    unique case (state_q)
      S_ADMIT: begin
        if (out_free && admit_ok) begin
          cmd.op = CMD_ADMIT;
        end
        tgt = SW'(in_q.slot);
      end
      S_WAIT: begin
        cmd.op  = CMD_WAIT;
        cmd.sel = last_v_q;
        tgt     = last_q;
      end
      S_RET_APPLY: begin
        cmd.op = CMD_RETURN;
        tgt    = ret_slot_q;
      end
      S_ROTATE: begin
        if (rot_q && last_v_q) begin
          cmd.op = CMD_STAMP;
        end
        tgt = last_q;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.op = CMD_FINISH;
        end
        cmd.sel = pick_v_q;
        cmd.clr = clr_q;
        tgt     = pick_slot_q;
      end
      default: begin
      end
    endcase
  end

  // State, sequencing and scheduler-wide registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      boost_q     <= 5'd0;
      oc_q        <= 16'd0;
      last_v_q    <= 1'b0;
      last_q      <= '0;
      rot_q       <= 1'b0;
      out_valid_q <= 1'b0;
      pick_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_PASS_A) || (state_q == S_PASS_RET) || (state_q == S_PASS_C)) begin
        cnt_q <= pass_end ? '0 : cnt_q + CW'(1);
      end
      // A new result loads the output register; otherwise a transfer empties it.
      if (((state_q == S_ADMIT) || (state_q == S_FINISH)) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_ADMIT: begin
          if (out_free) begin
            if (admit_ok) begin
              oc_q <= oc_q + 16'd1;
              if (last_v_q && (last_q == SW'(in_q.slot))) begin
                last_v_q <= 1'b0;
                rot_q    <= 1'b0;
              end
            end
          end
        end
        S_PASS_A: begin
          if (pass_end && (boost_q == 5'd0) && (st4 || st5)) begin
            boost_q <= 5'd1;
          end
        end
        S_RET_APPLY: oc_q <= oc_q + 16'd1;
        S_ROTATE: begin
          if (rot_q && last_v_q) begin
            oc_q <= oc_q + 16'd1;
          end
          rot_q <= 1'b0;
        end
        S_PASS_C: begin
          if (pass_end) begin
            boost_q  <= dec_boost;
            pick_v_q <= dec_v;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            last_v_q    <= pick_v_q;
            last_q      <= pick_slot_q;
            if (pick_v_q) begin
              rot_q <= rot_set_q;
              if (done_q) begin
                oc_q <= oc_q + 16'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Item, pick and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if ((state_q == S_PASS_RET) && pass_end) begin
      ret_slot_q <= chain_slot[SLOTS][RET_LANE];
    end
    if ((state_q == S_PASS_C) && pass_end) begin
      pick_slot_q <= dec_slot;
      pick_lvl_q  <= dec_lvl;
      clr_q       <= dec_clr;
      boosted_q   <= dec_boosted;
      done_q      <= (dec_cand.cpu <= 4'd1);
      rot_set_q   <= (dec_cand.cpu > 4'd1) &&
                     ((dec_lvl == LVL_RR_LO) || (dec_lvl == LVL_RR_HI)) &&
                     (dec_cand.slice <= 2'd1);
    end
    if ((state_q == S_ADMIT) && out_free) begin
      out_q <= '0;
    end
    if ((state_q == S_FINISH) && out_free) begin
      if (pick_v_q) begin
        out_q.run_valid  <= 1'b1;
        out_q.run_slot   <= 4'(pick_slot_q);
        out_q.run_level  <= pick_lvl_q;
        out_q.burst_done <= done_q;
        out_q.boosted    <= boosted_q;
      end else begin
        out_q <= '0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q       <= QUANTUM_RST;
      batch_lim_q     <= BATCH_LIMIT_RST;
      student_lim_q   <= STUDENT_LIMIT_RST;
      batch_boost_q   <= BATCH_BOOST_RST;
      student_boost_q <= STUDENT_BOOST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_QUANTUM:       quantum_q       <= cfg_data_i[1:0];
        CFG_BATCH_LIMIT:   batch_lim_q     <= cfg_data_i;
        CFG_STUDENT_LIMIT: student_lim_q   <= cfg_data_i;
        CFG_BATCH_BOOST:   batch_boost_q   <= cfg_data_i[4:0];
        CFG_STUDENT_BOOST: student_boost_q <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import mqts_pkg::*;

  localparam int NSLOT = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = CFG_QUANTUM;
  logic [9:0] cfg_data_i = '0;

  multilevel_queue_tick_scheduler #(.SLOTS(NSLOT)) DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the scheduler state and configuration.
  logic [1:0] q_len;
  logic [9:0] batch_lim, student_lim;
  logic [4:0] batch_boost, student_boost;
  logic sl_valid [NSLOT];
  logic [2:0] sl_level [NSLOT];
  logic [3:0] sl_cpu [NSLOT];
  logic [3:0] sl_io [NSLOT];
  logic sl_in_io [NSLOT];
  logic [9:0] sl_wait [NSLOT];
  logic [1:0] sl_slice [NSLOT];
  logic [15:0] sl_stamp [NSLOT];
  logic [15:0] next_stamp;
  logic [4:0] boost_cnt;
  logic runner_valid;
  logic [3:0] runner;
  logic rotate_due;

  out_t pending_runs[$];
  int fail_count = 0;
  bit long_hold_req = 1'b0;

  function automatic logic [3:0] cpu_base(input logic [2:0] l);
    case (l)
      LVL_SJF: return 4'd1;
      LVL_RR_LO: return 4'd3;
      LVL_RR_HI: return 4'd4;
      LVL_BATCH: return 4'd6;
      LVL_STUDENT: return 4'd8;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic [3:0] wait_base(input logic [2:0] l);
    case (l)
      LVL_SJF: return 4'd8;
      LVL_RR_LO: return 4'd6;
      LVL_RR_HI: return 4'd4;
      LVL_BATCH: return 4'd3;
      LVL_STUDENT: return 4'd1;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic [15:0] stamp_age(input int i);
    return next_stamp - sl_stamp[i];
  endfunction

  function automatic logic [15:0] grab_stamp();
    logic [15:0] s;
    s = next_stamp;
    next_stamp = next_stamp + 16'd1;
    return s;
  endfunction

  function automatic logic [1:0] slice_reload();
    return (q_len == 2'd0) ? 2'd1 : q_len;
  endfunction

  // Head of one level: shortest burst for level one, oldest stamp otherwise.
  function automatic int level_head(input logic [2:0] l);
    int h;
    h = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (!sl_valid[i] || sl_in_io[i] || sl_level[i] != l) continue;
      if (h < 0) h = i;
      else if (l == LVL_SJF) begin
        if (sl_cpu[i] < sl_cpu[h] ||
            (sl_cpu[i] == sl_cpu[h] && stamp_age(i) > stamp_age(h))) h = i;
      end else if (stamp_age(i) > stamp_age(h)) h = i;
    end
    return h;
  endfunction

  function automatic int starved(input logic [2:0] l, input logic [9:0] lim);
    int h;
    h = level_head(l);
    if (h >= 0 && sl_wait[h] > lim) return h;
    return -1;
  endfunction

  function automatic void sched_reset();
    q_len = QUANTUM_RST; batch_lim = BATCH_LIMIT_RST; student_lim = STUDENT_LIMIT_RST;
    batch_boost = BATCH_BOOST_RST; student_boost = STUDENT_BOOST_RST;
    for (int i = 0; i < NSLOT; i++) begin
      sl_valid[i] = 0; sl_level[i] = 0; sl_cpu[i] = 0; sl_io[i] = 0;
      sl_in_io[i] = 0; sl_wait[i] = 0; sl_slice[i] = 0; sl_stamp[i] = 0;
    end
    next_stamp = 0; boost_cnt = 0; runner_valid = 0; runner = 0; rotate_due = 0;
  endfunction

  // Expected outcome of one admit or tick, updating the shadow state.
  function automatic out_t sched_step(input in_t d);
    out_t r;
    int pick, h, rt;
    logic [4:0] lim;
    logic [2:0] pl;
    r = '0;
    pick = -1;
    if (d.op == OP_ADMIT) begin
      if (d.level >= 3'd1 && d.level <= 3'd5) begin
        if (runner_valid && runner == d.slot) begin
          runner_valid = 0;
          rotate_due = 0;
        end
        sl_valid[d.slot] = 1;
        sl_level[d.slot] = d.level;
        sl_cpu[d.slot] = cpu_base(d.level) + d.burst_offset;
        sl_io[d.slot] = 0;
        sl_in_io[d.slot] = 0;
        sl_wait[d.slot] = 0;
        sl_slice[d.slot] = slice_reload();
        sl_stamp[d.slot] = grab_stamp();
      end
      return r;
    end
    if (boost_cnt == 0 && (starved(LVL_BATCH, batch_lim) >= 0 ||
                           starved(LVL_STUDENT, student_lim) >= 0))
      boost_cnt = 1;
    for (int i = 0; i < NSLOT; i++) begin
      if (!sl_valid[i] || sl_in_io[i] || (runner_valid && runner == i)) continue;
      if (sl_wait[i] < WAIT_MAX) sl_wait[i]++;
    end
    // Tasks whose I/O ran out come back, oldest first.
    forever begin
      rt = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (!sl_valid[i] || !sl_in_io[i] || sl_io[i] != 0) continue;
        if (rt < 0 || stamp_age(i) > stamp_age(rt)) rt = i;
      end
      if (rt < 0) break;
      sl_in_io[rt] = 0;
      sl_cpu[rt] = cpu_base(sl_level[rt]) + d.burst_offset;
      sl_stamp[rt] = grab_stamp();
    end
    if (rotate_due) begin
      if (runner_valid && sl_valid[runner] && !sl_in_io[runner] &&
          (sl_level[runner] == LVL_RR_LO || sl_level[runner] == LVL_RR_HI))
        sl_stamp[runner] = grab_stamp();
      rotate_due = 0;
    end
    if (boost_cnt != 0) begin
      h = starved(LVL_BATCH, batch_lim);
      lim = batch_boost;
      if (h < 0) begin
        h = starved(LVL_STUDENT, student_lim);
        lim = student_boost;
      end
      if (h >= 0) begin
        boost_cnt = boost_cnt + 5'd1;
        if (boost_cnt >= lim) begin
          boost_cnt = 0;
          sl_wait[h] = 0;
        end
        pick = h;
        r.boosted = 1;
      end else boost_cnt = 0;
    end
    for (int l = 1; l <= 5 && pick < 0; l++) pick = level_head(l[2:0]);
    for (int i = 0; i < NSLOT; i++)
      if (sl_valid[i] && sl_in_io[i] && sl_io[i] > 0) sl_io[i]--;
    if (pick < 0) begin
      runner_valid = 0;
      return '0;
    end
    pl = sl_level[pick];
    if (sl_cpu[pick] > 0) sl_cpu[pick]--;
    if (sl_cpu[pick] == 0) begin
      r.burst_done = 1;
      sl_in_io[pick] = 1;
      sl_io[pick] = wait_base(pl) + d.io_offset;
      sl_slice[pick] = slice_reload();
      sl_stamp[pick] = grab_stamp();
    end else if (pl == LVL_RR_LO || pl == LVL_RR_HI) begin
      if (sl_slice[pick] <= 2'd1) begin
        sl_slice[pick] = slice_reload();
        rotate_due = 1;
      end else sl_slice[pick]--;
    end
    runner_valid = 1;
    runner = pick[3:0];
    r.run_valid = 1;
    r.run_slot = pick[3:0];
    r.run_level = pl;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input out_t got, input out_t want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Result checker and receiver stall pattern.
  int stall_left = 0;
  int stall_mode = 0;
  int hold_left = 0;
  out_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_runs.size() == 0) report_mismatch("unexpected", out_data_o, '0);
      else begin
        want = pending_runs.pop_front();
        if (out_data_o.run_valid !== want.run_valid) report_mismatch("run_valid", out_data_o, want);
        if (out_data_o.run_slot !== want.run_slot) report_mismatch("run_slot", out_data_o, want);
        if (out_data_o.run_level !== want.run_level) report_mismatch("run_level", out_data_o, want);
        if (out_data_o.burst_done !== want.burst_done)
          report_mismatch("burst_done", out_data_o, want);
        if (out_data_o.boosted !== want.boosted) report_mismatch("boosted", out_data_o, want);
      end
    end
    if (long_hold_req && hold_left == 0) begin
      hold_left = 3000;
      long_hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_left = $urandom_range(400, 10);
        stall_mode = $urandom_range(3, 0);
      end
      stall_left--;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(3, 0) == 0);
        2: out_stall_i <= ($urandom_range(1, 0) == 0);
        default: out_stall_i <= ($urandom_range(7, 0) != 0);
      endcase
    end
  end

  // Offer one item and wait for the transfer.
  int burst_left = 0;
  task automatic send_item(input in_t d, input bit fixed, input out_t fixed_out);
    out_t p;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(($urandom_range(2, 0) == 0) ? 40 : 3, 0);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(30, 1);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    p = sched_step(d);
    pending_runs.push_back(fixed ? fixed_out : p);
  endtask

  task automatic drain_and_idle();
    in_valid_i <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // One register write; the caller drops the write enable after the last one.
  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_QUANTUM: q_len = val[1:0];
      CFG_BATCH_LIMIT: batch_lim = val;
      CFG_STUDENT_LIMIT: student_lim = val;
      CFG_BATCH_BOOST: batch_boost = val[4:0];
      CFG_STUDENT_BOOST: student_boost = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [1:0] q, input logic [9:0] bl, input logic [9:0] sl,
                            input logic [4:0] bb, input logic [4:0] sb);
    write_reg(CFG_QUANTUM, {8'd0, q});
    write_reg(CFG_BATCH_LIMIT, bl);
    write_reg(CFG_STUDENT_LIMIT, sl);
    write_reg(CFG_BATCH_BOOST, {5'd0, bb});
    write_reg(CFG_STUDENT_BOOST, {5'd0, sb});
  endtask

  function automatic in_t mk(input logic op, input logic [3:0] s, input logic [2:0] l,
                             input logic [1:0] bo, input logic [1:0] io);
    in_t d;
    d.op = op; d.slot = s; d.level = l; d.burst_offset = bo; d.io_offset = io;
    return d;
  endfunction

  // Random item: mostly ticks, admits mostly to valid levels.
  function automatic in_t rand_item();
    logic [2:0] l;
    if ($urandom_range(9, 0) < 3) begin
      l = ($urandom_range(15, 0) == 0) ? 3'($urandom_range(7, 0)) : 3'($urandom_range(5, 1));
      return mk(OP_ADMIT, 4'($urandom), l, 2'($urandom), 2'($urandom));
    end
    return mk(OP_TICK, 4'($urandom), 3'($urandom), 2'($urandom), 2'($urandom));
  endfunction

  typedef struct {
    in_t d;
    bit fixed;
    out_t result;
  } stim_row_t;

  stim_row_t directed[25];

  initial begin
    directed[0]  = '{mk(OP_TICK, 4'd0, 3'd0, 2'd0, 2'd0), 1, '0};
    directed[1]  = '{mk(OP_ADMIT, 4'd0, LVL_SJF, 2'd0, 2'd0), 1, '0};
    directed[2]  = '{mk(OP_ADMIT, 4'd15, LVL_STUDENT, 2'd3, 2'd3), 1, '0};
    directed[3]  = '{mk(OP_ADMIT, 4'd3, 3'd0, 2'd1, 2'd1), 1, '0};
    directed[4]  = '{mk(OP_ADMIT, 4'd4, 3'd7, 2'd2, 2'd2), 1, '0};
    directed[5]  = '{mk(OP_ADMIT, 4'd1, LVL_RR_LO, 2'd1, 2'd0), 1, '0};
    directed[6]  = '{mk(OP_ADMIT, 4'd2, LVL_RR_HI, 2'd2, 2'd1), 1, '0};
    directed[7]  = '{mk(OP_ADMIT, 4'd5, LVL_BATCH, 2'd0, 2'd2), 1, '0};
    directed[8]  = '{mk(OP_ADMIT, 4'd6, LVL_SJF, 2'd3, 2'd0), 1, '0};
    for (int i = 9; i < 20; i++)
      directed[i] = '{mk(OP_TICK, 4'(i), 3'(i), 2'(i), 2'(i >> 1)), 0, '0};
    directed[20] = '{mk(OP_ADMIT, 4'd1, LVL_RR_LO, 2'd0, 2'd0), 1, '0};
    for (int i = 21; i < 25; i++)
      directed[i] = '{mk(OP_TICK, 4'd15, 3'd7, 2'd3, 2'd3), 0, '0};
  end

  // Stimulus: directed rows, then random phases over several settings.
  initial begin
    sched_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_item(directed[i].d, directed[i].fixed, directed[i].result);
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_idle();
      case (ph)
        1: set_config(2'd1, 10'd0, 10'd0, 5'd1, 5'd1);
        2: begin
          set_config(2'd0, 10'd1023, 10'd1023, 5'd31, 5'd31);
          long_hold_req = 1;
        end
        3: begin
          set_config(2'd2, 10'd5, 10'd12, 5'd4, 5'd3);
          write_reg(3'd7, 10'h3ff);
        end
        4: set_config(2'd3, 10'd100, 10'd250, 5'd30, 5'd12);
        default: ;
      endcase
      cfg_we_i <= 1'b0;
      repeat (275) send_item(rand_item(), 0, '0);
    end
    in_valid_i <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
